### hdl/pkwr_pkg.sv
// Package: shared types and constants of the per-key window ring counters.
`timescale 1ns / 1ps
`default_nettype none

package pkwr_pkg;

   localparam int KEY_W   = 5;
   localparam int AMT_W   = 32;
   localparam int SUM_W   = 64;
   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   typedef enum logic {
      KIND_RECORD  = 1'b0,
      KIND_ADVANCE = 1'b1
   } pkwr_kind_type;

   typedef struct packed {
      pkwr_kind_type          kind;
      logic [KEY_W-1:0]       key;
      logic [AMT_W-1:0]       edge_amount;
      logic [AMT_W-1:0]       time_amount;
   } pkwr_item_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic          valid;
      pkwr_item_type item;
   } pkwr_qhead_type;

   // Back end control toward the front end.
   typedef struct packed {
      logic pop;
      logic clearing;
   } pkwr_qctl_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_REC_WR,
      BK_ADV,
      BK_ADV_END
   } pkwr_bstate_type;

endpackage

`default_nettype wire

### hdl/per_key_window_ring_counters.sv
// Top level: per-key sliding window ring counters with front queue and back engine.
//
// Usage:
//   Request channel (req_*): one beat is either a record (kind 0) that adds
//   edge and time amounts to a key's active window slot and running sums, or
//   an advance (kind 1) that rotates the window for keys 1 to NUM_KEYS-1.
//   Response channel (rsp_*): one beat per record whose key is below NUM_KEYS,
//   carrying the key and both running sums after the add. Advances and
//   out-of-range records give no response.
//   A beat moves when valid is high and stall is low at a rising clock edge.
//   A record passes its queue entry, the back end's idle and write states
//   and the response register; the write waits while a stalled response is
//   held. The back end takes the next record only after the read-modify-write
//   of the slot and sum memories. An advance occupies the back end, one key
//   per cycle through the memory read port plus the pointer update.
//   Reset: synchronous. Afterwards a clearing pass writes zero to every ring
//   entry, NUM_KEYS * 2^ceil(log2(NUM_WINDOWS)) of them (256 by default),
//   while req_stall stays high.
//   A stalled response holds in its output register; the back end keeps the
//   next record waiting and the two-entry queue keeps accepting until full.
`timescale 1ns / 1ps
`default_nettype none

module per_key_window_ring_counters #(
   parameter int NUM_KEYS    = 32,
   parameter int NUM_WINDOWS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_kind,
   input  wire logic [pkwr_pkg::KEY_W-1:0]    req_key,
   input  wire logic [pkwr_pkg::AMT_W-1:0]    req_edge_amount,
   input  wire logic [pkwr_pkg::AMT_W-1:0]    req_time_amount,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [pkwr_pkg::KEY_W-1:0]         rsp_key_out,
   output logic [pkwr_pkg::SUM_W-1:0]         rsp_edge_recent_sum,
   output logic [pkwr_pkg::SUM_W-1:0]         rsp_time_recent_sum
);
   import pkwr_pkg::*;

   // queue head toward the back end, pop and clear status back to the front
   pkwr_qhead_type qhead;
   pkwr_qctl_type  qctl;

   // Front: accept beats, drop records for keys without counters, queue the rest.
   pkwr_front #(
      .NUM_KEYS (NUM_KEYS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_key         (req_key),
      .req_edge_amount (req_edge_amount),
      .req_time_amount (req_time_amount),
      .qctl            (qctl),
      .qhead           (qhead)
   );

   // Back: clear memories after reset, then run records and advance walks.
   pkwr_back #(
      .NUM_KEYS    (NUM_KEYS),
      .NUM_WINDOWS (NUM_WINDOWS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .qhead               (qhead),
      .qctl                (qctl),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_key_out         (rsp_key_out),
      .rsp_edge_recent_sum (rsp_edge_recent_sum),
      .rsp_time_recent_sum (rsp_time_recent_sum)
   );

endmodule

`default_nettype wire

### hdl/pkwr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pkwr_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 256
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/pkwr_front.sv
// Front end: accept request beats, drop out-of-range records, queue the rest.
`timescale 1ns / 1ps
`default_nettype none

module pkwr_front #(
   parameter int NUM_KEYS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_kind,
   input  wire logic [pkwr_pkg::KEY_W-1:0]         req_key,
   input  wire logic [pkwr_pkg::AMT_W-1:0]         req_edge_amount,
   input  wire logic [pkwr_pkg::AMT_W-1:0]         req_time_amount,
   input  wire pkwr_pkg::pkwr_qctl_type            qctl,
   output pkwr_pkg::pkwr_qhead_type                qhead
);
   import pkwr_pkg::*;

   pkwr_item_type         q_mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;
   pkwr_item_type         item_in;
   logic                  accept;
   logic                  keep;
   logic                  push;

   always_comb begin
      item_in.kind        = pkwr_kind_type'(req_kind);
      item_in.key         = req_key;
      item_in.edge_amount = req_edge_amount;
      item_in.time_amount = req_time_amount;
   end

   assign req_stall = (cnt_ff == QCNT_W'(Q_DEPTH)) || qctl.clearing;
   assign accept    = req_valid && !req_stall;
   // drop records whose key has no counters
   assign keep      = (item_in.kind == KIND_ADVANCE) || (32'(req_key) < 32'(NUM_KEYS));
   assign push      = accept && keep;

   always_comb begin
      wr_ptr_in = push      ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = qctl.pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(qctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign qhead.valid = (cnt_ff != '0);
   assign qhead.item  = q_mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### hdl/pkwr_back.sv
// Back end: clear pass, record read-modify-write, window advance walk, result register.
`timescale 1ns / 1ps
`default_nettype none

module pkwr_back #(
   parameter int NUM_KEYS    = 32,
   parameter int NUM_WINDOWS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire pkwr_pkg::pkwr_qhead_type           qhead,
   output pkwr_pkg::pkwr_qctl_type                 qctl,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [pkwr_pkg::KEY_W-1:0]              rsp_key_out,
   output logic [pkwr_pkg::SUM_W-1:0]              rsp_edge_recent_sum,
   output logic [pkwr_pkg::SUM_W-1:0]              rsp_time_recent_sum
);
   import pkwr_pkg::*;

   localparam int KEY_IDX_W  = $clog2(NUM_KEYS);
   localparam int SLOT_W     = $clog2(NUM_WINDOWS);
   localparam int RING_DEPTH = NUM_KEYS << SLOT_W;
   localparam int RING_AW    = KEY_IDX_W + SLOT_W;
   localparam int KEY_EXT_W  = (KEY_IDX_W > KEY_W) ? KEY_IDX_W : KEY_W;
   localparam int PAIR_W     = 2 * SUM_W;

   function automatic logic [KEY_IDX_W-1:0] key_index(input logic [KEY_W-1:0] k);
      logic [KEY_EXT_W-1:0] w;
      w = KEY_EXT_W'(k);
      return w[KEY_IDX_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] sat_sub(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
      return (a >= b) ? (a - b) : '0;
   endfunction

   pkwr_bstate_type       state_ff, state_in;
   logic [SLOT_W-1:0]     active_slot_ff, active_slot_in;
   pkwr_item_type         op_ff, op_in;
   logic [KEY_IDX_W-1:0]  adv_key_ff, adv_key_in;
   logic                  wb_vld_ff, wb_vld_in;
   logic [KEY_IDX_W-1:0]  wb_key_ff, wb_key_in;
   logic [RING_AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]      rsp_key_ff, rsp_key_in;
   logic [SUM_W-1:0]      rsp_edge_ff, rsp_edge_in;
   logic [SUM_W-1:0]      rsp_time_ff, rsp_time_in;

   logic [SLOT_W-1:0]     next_slot;
   logic [KEY_IDX_W-1:0]  rd_key;
   logic [SLOT_W-1:0]     rd_slot;
   logic                  ring_we, sum_we;
   logic [RING_AW-1:0]    ring_wr_addr;
   logic [KEY_IDX_W-1:0]  sum_wr_addr;
   logic [PAIR_W-1:0]     ring_wr_data, sum_wr_data;
   logic [PAIR_W-1:0]     ring_rd_data, sum_rd_data;
   logic [SUM_W-1:0]      ring_edge, ring_time, sum_edge, sum_time;
   logic [SUM_W-1:0]      new_edge_sum, new_time_sum;

   assign next_slot = (active_slot_ff == SLOT_W'(NUM_WINDOWS - 1)) ? '0
                                                                   : active_slot_ff + SLOT_W'(1);
   assign {ring_edge, ring_time} = ring_rd_data;
   assign {sum_edge, sum_time}   = sum_rd_data;
   assign new_edge_sum = sum_edge + SUM_W'(op_ff.edge_amount);
   assign new_time_sum = sum_time + SUM_W'(op_ff.time_amount);

   always_comb begin
      state_in       = state_ff;
      active_slot_in = active_slot_ff;
      op_in          = op_ff;
      adv_key_in     = adv_key_ff;
      wb_vld_in      = 1'b0;
      wb_key_in      = wb_key_ff;
      clr_cnt_in     = clr_cnt_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_edge_in    = rsp_edge_ff;
      rsp_time_in    = rsp_time_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      qctl.pop       = 1'b0;
      qctl.clearing  = 1'b0;
      rd_key         = '0;
      rd_slot        = '0;
      ring_we        = 1'b0;
      sum_we         = 1'b0;
      ring_wr_addr   = '0;
      sum_wr_addr    = '0;
      ring_wr_data   = '0;
      sum_wr_data    = '0;

      unique case (state_ff)
         BK_CLEAR: begin
            qctl.clearing = 1'b1;
            ring_we       = 1'b1;
            ring_wr_addr  = clr_cnt_ff;
            sum_we        = (32'(clr_cnt_ff) < 32'(NUM_KEYS));
            sum_wr_addr   = clr_cnt_ff[KEY_IDX_W-1:0];
            clr_cnt_in    = clr_cnt_ff + RING_AW'(1);
            if (clr_cnt_ff == RING_AW'(RING_DEPTH - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            rd_key  = key_index(qhead.item.key);
            rd_slot = active_slot_ff;
            if (qhead.valid) begin
               qctl.pop = 1'b1;
               op_in    = qhead.item;
               if (qhead.item.kind == KIND_ADVANCE) begin
                  adv_key_in = KEY_IDX_W'(1);
                  state_in   = BK_ADV;
               end else begin
                  state_in = BK_REC_WR;
               end
            end
         end
         BK_REC_WR: begin
            rd_key  = key_index(op_ff.key);
            rd_slot = active_slot_ff;
            if (!rsp_valid_ff || !rsp_stall) begin
               ring_we      = 1'b1;
               ring_wr_addr = {key_index(op_ff.key), active_slot_ff};
               ring_wr_data = {ring_edge + SUM_W'(op_ff.edge_amount),
                               ring_time + SUM_W'(op_ff.time_amount)};
               sum_we       = 1'b1;
               sum_wr_addr  = key_index(op_ff.key);
               sum_wr_data  = {new_edge_sum, new_time_sum};
               rsp_valid_in = 1'b1;
               rsp_key_in   = op_ff.key;
               rsp_edge_in  = new_edge_sum;
               rsp_time_in  = new_time_sum;
               state_in     = BK_IDLE;
            end
         end
         BK_ADV, BK_ADV_END: begin
            rd_key  = adv_key_ff;
            rd_slot = next_slot;
            if (wb_vld_ff) begin
               ring_we      = 1'b1;
               ring_wr_addr = {wb_key_ff, next_slot};
               sum_we       = 1'b1;
               sum_wr_addr  = wb_key_ff;
               sum_wr_data  = {sat_sub(sum_edge, ring_edge), sat_sub(sum_time, ring_time)};
            end
            if (state_ff == BK_ADV) begin
               wb_vld_in = 1'b1;
               wb_key_in = adv_key_ff;
               if (adv_key_ff == KEY_IDX_W'(NUM_KEYS - 1)) begin
                  state_in = BK_ADV_END;
               end else begin
                  adv_key_in = adv_key_ff + KEY_IDX_W'(1);
               end
            end else begin
               active_slot_in = next_slot;
               state_in       = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_CLEAR;
         active_slot_ff <= '0;
         adv_key_ff     <= '0;
         wb_vld_ff      <= 1'b0;
         clr_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_slot_ff <= active_slot_in;
         adv_key_ff     <= adv_key_in;
         wb_vld_ff      <= wb_vld_in;
         clr_cnt_ff     <= clr_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      wb_key_ff   <= wb_key_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_edge_ff <= rsp_edge_in;
      rsp_time_ff <= rsp_time_in;
   end

   pkwr_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (RING_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_addr ({rd_key, rd_slot}),
      .rd_data (ring_rd_data)
   );

   pkwr_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (NUM_KEYS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_wr_addr),
      .wr_data (sum_wr_data),
      .rd_addr (rd_key),
      .rd_data (sum_rd_data)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_key_out         = rsp_key_ff;
   assign rsp_edge_recent_sum = rsp_edge_ff;
   assign rsp_time_recent_sum = rsp_time_ff;

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !rsp_valid_ff)
      else $error("result pending during clear pass");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      32'(active_slot_ff) < 32'(NUM_WINDOWS))
      else $error("slot pointer out of range");

   a_slot_moves_at_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BK_ADV_END) |=> (active_slot_ff == $past(active_slot_ff)))
      else $error("slot pointer moved outside advance end");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_key_ff)
         && $stable(rsp_edge_ff) && $stable(rsp_time_ff)))
      else $error("stalled result changed");

   a_rsp_load_from_wr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall) && $past(!reset))
         |-> $past(state_ff == BK_REC_WR))
      else $error("result loaded outside record write");

endmodule

`default_nettype wire
